>>> hdl/lamp_duty_softstart_compensator_unit_defines.svh
// assertion helpers used by the checker file
`ifndef LAMP_DUTY_SOFTSTART_COMPENSATOR_UNIT_DEFINES_SVH
`define LAMP_DUTY_SOFTSTART_COMPENSATOR_UNIT_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define LDSC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// consequent checked in the cycle after the antecedent
`define LDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/ldsc_pkg.sv
package ldsc_pkg;

  localparam int AdcBits  = 10;
  localparam int AdcShift = AdcBits - 8;

  localparam logic [7:0] SoftLimit = 8'd30;
  localparam logic [7:0] DutyMax   = 8'hFF;

  localparam int DivSteps = 16;
  localparam int DivCntW  = $clog2(DivSteps);

  typedef enum logic [2:0] {
    MODE_RATIO      = 3'd0,
    MODE_RATIO_INV  = 3'd1,
    MODE_VOLT       = 3'd2,
    MODE_RATIO_SOFT = 3'd3,
    MODE_VOLT_SOFT  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    CFG_MODE_ONE = 2'd0,
    CFG_MODE_TWO = 2'd1
  } cfg_idx_t;

  typedef struct packed {
    logic [7:0] setpoint_one;
    logic [7:0] setpoint_two;
    logic [7:0] programmed_level_one;
    logic [7:0] programmed_level_two;
    logic [9:0] battery_sample;
  } in_t;

  typedef struct packed {
    logic [7:0] duty_one;
    logic [7:0] duty_two;
    logic       invert_one;
    logic       invert_two;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic div_step;
    logic upd;
    logic out_load;
    logic ch;
  } cmd_t;

endpackage

>>> hdl/ldsc_ctrl.sv
module ldsc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output ldsc_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_DIV  = 5'b00100,
    S_UPD  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t                       state_r, state_nxt;
  logic                         ch_r, ch_nxt;
  logic [ldsc_pkg::DivCntW-1:0] cnt_r, cnt_nxt;
  logic                         out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    cmd.ch        = ch_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          ch_nxt    = 1'b0;
          state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == ldsc_pkg::DivCntW'(ldsc_pkg::DivSteps - 1)) begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        cmd.upd = 1'b1;
        if (ch_r) begin
          state_nxt = S_DONE;
        end else begin
          ch_nxt    = 1'b1;
          state_nxt = S_MUL;
        end
      end
      S_DONE: begin
        // output register free or being emptied this cycle
        if (!out_valid_r || !out_stall) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

>>> hdl/ldsc_datapath.sv
module ldsc_datapath (
  input  logic           clk,
  input  logic           rst_n,
  input  ldsc_pkg::cmd_t cmd,
  input  ldsc_pkg::in_t  in_data,
  input  logic           cfg_we,
  input  logic [1:0]     cfg_index,
  input  logic [2:0]     cfg_data,
  output ldsc_pkg::out_t out_data
);

  function automatic logic [7:0] soft_step(input logic [7:0] cur, input logic [7:0] target);
    if (cur > target || cur > ldsc_pkg::SoftLimit) begin
      return target;
    end
    return cur + 8'd1;
  endfunction

  ldsc_pkg::in_t  in_r;
  ldsc_pkg::out_t out_r;
  logic [2:0]     mode_one_r, mode_two_r;
  logic [7:0]     applied_one_r, applied_two_r;
  logic [15:0]    q_r;
  logic [7:0]     rem_r;

  logic [7:0]  volts;
  logic [7:0]  sel_set, sel_level, sel_cur;
  logic [2:0]  sel_mode;
  logic [8:0]  rem_sh;
  logic        ge;
  logic [7:0]  comp;
  logic [7:0]  new_duty;

  assign volts     = 8'(in_r.battery_sample >> ldsc_pkg::AdcShift);
  assign sel_set   = cmd.ch ? in_r.setpoint_two : in_r.setpoint_one;
  assign sel_level = cmd.ch ? in_r.programmed_level_two : in_r.programmed_level_one;
  assign sel_cur   = cmd.ch ? applied_two_r : applied_one_r;
  assign sel_mode  = cmd.ch ? mode_two_r : mode_one_r;

  // restoring division, one quotient bit a cycle
  assign rem_sh = {rem_r, q_r[15]};
  assign ge     = rem_sh >= {1'b0, volts};

  always_comb begin
    if (volts == 8'd0) begin
      comp = 8'd0;
    end else if (q_r[15:8] != 8'd0) begin
      comp = ldsc_pkg::DutyMax;
    end else begin
      comp = q_r[7:0];
    end
  end

  always_comb begin
    if (sel_set == 8'd0) begin
      new_duty = 8'd0;
    end else begin
      unique case (sel_mode)
        ldsc_pkg::MODE_RATIO,
        ldsc_pkg::MODE_RATIO_INV:  new_duty = sel_set;
        ldsc_pkg::MODE_VOLT:       new_duty = comp;
        ldsc_pkg::MODE_RATIO_SOFT: new_duty = soft_step(sel_cur, sel_set);
        ldsc_pkg::MODE_VOLT_SOFT:  new_duty = soft_step(sel_cur, comp);
        default:                   new_duty = sel_cur;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_one_r    <= ldsc_pkg::MODE_RATIO;
      mode_two_r    <= ldsc_pkg::MODE_RATIO;
      applied_one_r <= 8'd0;
      applied_two_r <= 8'd0;
    end else begin
      if (cfg_we && cfg_index == ldsc_pkg::CFG_MODE_ONE) begin
        mode_one_r <= cfg_data;
      end
      if (cfg_we && cfg_index == ldsc_pkg::CFG_MODE_TWO) begin
        mode_two_r <= cfg_data;
      end
      if (cmd.upd && !cmd.ch) begin
        applied_one_r <= new_duty;
      end
      if (cmd.upd && cmd.ch) begin
        applied_two_r <= new_duty;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.mul) begin
      q_r   <= {8'd0, sel_set} * {8'd0, sel_level} + 16'd1;
      rem_r <= 8'd0;
    end else if (cmd.div_step) begin
      q_r   <= {q_r[14:0], ge};
      rem_r <= ge ? 8'(rem_sh - {1'b0, volts}) : rem_sh[7:0];
    end
    if (cmd.out_load) begin
      out_r.duty_one   <= applied_one_r;
      out_r.duty_two   <= applied_two_r;
      out_r.invert_one <= (mode_one_r == ldsc_pkg::MODE_RATIO_INV);
      out_r.invert_two <= (mode_two_r == ldsc_pkg::MODE_RATIO_INV);
    end
  end

  assign out_data = out_r;

endmodule

>>> hdl/lamp_duty_softstart_compensator_unit.sv
// one tick at a time: in_stall stays high from the taken input beat until the
//   result is loaded; each channel in turn takes a multiply step, a pass through
//   the shared bit-serial divider and an update step
// a finished result waits in the output register while the next tick is taken
// reset (rst_n low, synchronous) clears both modes to ratio, both applied duties
//   to zero and empties the output register
module lamp_duty_softstart_compensator_unit (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  ldsc_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output ldsc_pkg::out_t out_data,
  input  logic           cfg_valid,
  output logic           cfg_ready,
  input  logic [1:0]     cfg_index,
  input  logic [2:0]     cfg_data
);

  ldsc_pkg::cmd_t cmd;

  assign cfg_ready = 1'b1;

  ldsc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  ldsc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_data   (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data)
  );

endmodule

>>> hdl/ldsc_checker.sv
`include "lamp_duty_softstart_compensator_unit_defines.svh"

module ldsc_checker (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_stall,
  input logic           out_valid,
  input logic           out_stall,
  input ldsc_pkg::out_t out_data
);

  `LDSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result beat changed")
  `LDSC_ASSERT_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall, "input not stalled after a beat was taken")
  `LDSC_ASSERT_NOW(a_result_from_work, $rose(out_valid), $past(in_stall), "result appeared while the block was idle")
  `LDSC_ASSERT_NOW(a_busy_two, in_valid && !in_stall, ##1 in_stall ##1 in_stall, "block idle too soon after a tick")

endmodule

bind lamp_duty_softstart_compensator_unit ldsc_checker u_chk (.*);
